// ===== hdl/cts_pkg.sv =====
// Shared types, constants and saturating helpers for the coupled tridiagonal solver.
`timescale 1ns / 1ps
package cts_pkg;

	localparam int DEF_MAX_EQUATIONS = 64;
	localparam int DEF_FRACTION_BITS = 16;
	localparam int DW = 32;
	localparam int ROW_IDX_W = 6;

	localparam logic signed [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

	// One input row as it arrives
	typedef struct packed {
		logic signed [DW-1:0] a_coef;
		logic signed [DW-1:0] b_coef;
		logic signed [DW-1:0] c_coef;
		logic signed [DW-1:0] d_coef;
		logic signed [DW-1:0] e_coef;
		logic signed [DW-1:0] f_coef;
		logic signed [DW-1:0] g_coef;
		logic signed [DW-1:0] h_coef;
		logic                 coupled;
		logic                 last_row;
	} in_t;

	// One result row
	typedef struct packed {
		logic [ROW_IDX_W-1:0] row_index;
		logic signed [DW-1:0] solution;
		logic signed [DW-1:0] other_solution;
		logic                 has_other;
		logic                 divide_fault;
		logic                 last_result;
	} out_t;

	// One stored row of the equation memory
	typedef struct packed {
		logic signed [DW-1:0] a;
		logic signed [DW-1:0] b;
		logic signed [DW-1:0] c;
		logic signed [DW-1:0] d;
		logic signed [DW-1:0] e;
		logic signed [DW-1:0] f;
		logic signed [DW-1:0] g;
		logic signed [DW-1:0] h;
		logic                 cpl;
	} row_t;

	localparam int ROW_W = $bits(row_t);

	// Saturated value with overflow flag
	typedef struct packed {
		logic signed [DW-1:0] v;
		logic                 ovf;
	} sres_t;

	function automatic sres_t sat_sub(logic signed [DW-1:0] p, logic signed [DW-1:0] q);
		logic signed [DW:0] s;
		sres_t r;
		s = {p[DW-1], p} - {q[DW-1], q};
		r.ovf = (s[DW] != s[DW-1]);
		r.v = r.ovf ? (s[DW] ? SMIN : SMAX) : s[DW-1:0];
		return r;
	endfunction

	function automatic sres_t sat_neg(logic signed [DW-1:0] p);
		sres_t r;
		r.ovf = (p == SMIN);
		r.v = r.ovf ? SMAX : -p;
		return r;
	endfunction

	function automatic sres_t sat_wide(logic signed [2*DW-1:0] x);
		sres_t r;
		r.ovf = !((&x[2*DW-1:DW-1]) || !(|x[2*DW-1:DW-1]));
		r.v = r.ovf ? (x[2*DW-1] ? SMIN : SMAX) : x[DW-1:0];
		return r;
	endfunction

endpackage

// ===== hdl/coupled_tridiagonal_solver_core.sv =====
// Top level of the coupled tridiagonal solver: loader, job queue, row memory, solver.
//
// Usage: drive a row on item and raise start; the row transfers at a clock edge where
// start is high and busy is low. Rows load one per cycle into the row memory while busy is low. A row
// with last_row set closes the system and queues a solve job; busy stays high from the
// next cycle until the last result has been sent. The solver then makes one forward
// pass (pre-elimination of coupled rows and forward elimination) and one backward pass
// (backward elimination, division by the diagonal, other-domain unknown), then reads
// out one result per row on result, each marked by result_valid for one cycle.
// Throughput is set by the shared iterative divider: zero to two divisions per row
// forward and one to three backward. Results cannot be held off by the receiver.
// Reset clears the row count, fault flag, job queue and sequencer; the row memory
// holds no reset value and is only read after being written for the current system.
`timescale 1ns / 1ps
module coupled_tridiagonal_solver_core
	import cts_pkg::*;
#(
	parameter int MAX_EQUATIONS = DEF_MAX_EQUATIONS,
	parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  in_t  item,
	output logic result_valid,
	output out_t result
);
	localparam int AW = $clog2(MAX_EQUATIONS);
	localparam int CW = $clog2(MAX_EQUATIONS + 1);

	logic          accept;
	logic          f_we, b_we, job_push, job_pop, job_valid, back_active;
	logic [AW-1:0] f_addr, b_addr;
	row_t          f_row, b_row, rd_row;
	logic [CW:0]   job_in, job_head;

	assign busy = job_valid || back_active;
	assign accept = start && !busy;

	cts_front #(.MAX_EQUATIONS(MAX_EQUATIONS)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.item    (item),
		.wr_en   (f_we),
		.wr_addr (f_addr),
		.wr_row  (f_row),
		.job_push(job_push),
		.job_data(job_in)
	);

	cts_fifo #(.WIDTH(CW + 1)) u_jobq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_data(job_in),
		.pop      (job_pop),
		.not_empty(job_valid),
		.head     (job_head)
	);

	// the loader owns the write port while the solver is idle
	cts_ram #(.WIDTH(ROW_W), .DEPTH(MAX_EQUATIONS)) u_rows (
		.clk  (clk),
		.we   (back_active ? b_we : f_we),
		.waddr(back_active ? b_addr : f_addr),
		.wdata(back_active ? b_row : f_row),
		.raddr(b_addr),
		.rdata(rd_row)
	);

	cts_back #(.MAX_EQUATIONS(MAX_EQUATIONS), .FRACTION_BITS(FRACTION_BITS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (job_valid),
		.job_data    (job_head),
		.job_pop     (job_pop),
		.active      (back_active),
		.mem_addr    (b_addr),
		.mem_rd      (rd_row),
		.mem_we      (b_we),
		.mem_wr      (b_row),
		.result_valid(result_valid),
		.result      (result)
	);
endmodule

// ===== hdl/cts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module cts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hdl/cts_fifo.sv =====
// Two-entry queue carrying solve jobs from the loader to the solver.
`timescale 1ns / 1ps
module cts_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] head
);
	logic [WIDTH-1:0] slot_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign not_empty = (cnt_q != 2'd0);
	assign head = slot_q[rd_q];

	// pointer and count update; a push into a full queue is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && cnt_q != 2'd2) begin
				wr_q <= ~wr_q;
			end
			if (pop && not_empty) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push && cnt_q != 2'd2} - {1'b0, pop && not_empty};
		end
	end

	always_ff @(posedge clk) begin
		if (push && cnt_q != 2'd2) begin
			slot_q[wr_q] <= push_data;
		end
	end
endmodule

// ===== hdl/cts_div.sv =====
// Iterative fixed-point divider: (num << FRAC) / den, truncating, saturating.
`timescale 1ns / 1ps
module cts_div
	import cts_pkg::*;
#(
	parameter int FRAC = DEF_FRACTION_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [DW-1:0] num,
	input  logic signed [DW-1:0] den,
	output logic                 busy,
	output logic                 done,
	output logic signed [DW-1:0] quo,
	output logic                 fault
);
	localparam int QW = DW + FRAC;
	localparam int CW = $clog2(QW + 1);

	logic [QW-1:0] sh_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          neg_q;
	logic          busy_q, done_q;
	logic signed [DW-1:0] quo_q;
	logic          flt_q;

	logic [DW-1:0] num_mag, den_mag;
	logic [DW:0]   trial;
	logic          ge;

	assign num_mag = num[DW-1] ? DW'(-num) : DW'(num);
	assign den_mag = den[DW-1] ? DW'(-den) : DW'(den);
	assign trial = {rem_q, sh_q[QW-1]};
	assign ge = (trial >= {1'b0, den_q});

	assign busy = busy_q;
	assign done = done_q;
	assign quo = quo_q;
	assign fault = flt_q;

	// one quotient bit per cycle, then sign and saturation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				if (den == '0) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q <= CW'(QW);
				end
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			flt_q <= (den == '0);
			if (den == '0) begin
				quo_q <= (num == '0) ? '0 : (num[DW-1] ? SMIN : SMAX);
			end
			sh_q <= QW'(num_mag) << FRAC;
			rem_q <= '0;
			den_q <= den_mag;
			neg_q <= num[DW-1] ^ den[DW-1];
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				if (!neg_q) begin
					if ((sh_q >> (DW - 1)) != '0) begin
						quo_q <= SMAX;
						flt_q <= 1'b1;
					end else begin
						quo_q <= sh_q[DW-1:0];
					end
				end else begin
					if (sh_q > QW'(33'h0_8000_0000)) begin
						quo_q <= SMIN;
						flt_q <= 1'b1;
					end else begin
						quo_q <= -sh_q[DW-1:0];
					end
				end
			end else begin
				rem_q <= ge ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
				sh_q <= {sh_q[QW-2:0], ge};
			end
		end
	end
endmodule

// ===== hdl/cts_front.sv =====
// Loader: stores incoming rows and queues a solve job when the last row arrives.
`timescale 1ns / 1ps
module cts_front
	import cts_pkg::*;
#(
	parameter int MAX_EQUATIONS = DEF_MAX_EQUATIONS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             accept,
	input  in_t                              item,
	output logic                             wr_en,
	output logic [$clog2(MAX_EQUATIONS)-1:0] wr_addr,
	output row_t                             wr_row,
	output logic                             job_push,
	output logic [$clog2(MAX_EQUATIONS+1):0] job_data
);
	localparam int AW = $clog2(MAX_EQUATIONS);
	localparam int CW = $clog2(MAX_EQUATIONS + 1);

	logic [CW-1:0] count_q;
	logic          fault_q;
	logic          full;
	logic [CW-1:0] n_next;

	assign full = (count_q == CW'(MAX_EQUATIONS));
	assign n_next = full ? count_q : count_q + CW'(1);

	assign wr_en = accept && !full;
	assign wr_addr = count_q[AW-1:0];
	assign wr_row = '{a: item.a_coef, b: item.b_coef, c: item.c_coef, d: item.d_coef,
		e: item.e_coef, f: item.f_coef, g: item.g_coef, h: item.h_coef, cpl: item.coupled};

	// job: row count and fault so far (a dropped row counts as a fault)
	assign job_push = accept && item.last_row;
	assign job_data = {n_next, fault_q | full};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			fault_q <= 1'b0;
		end else if (accept) begin
			if (item.last_row) begin
				count_q <= '0;
				fault_q <= 1'b0;
			end else begin
				count_q <= n_next;
				fault_q <= fault_q | full;
			end
		end
	end
endmodule

// ===== hdl/cts_back.sv =====
// Solver sequencer: forward pass, backward pass with division, then result readout.
`timescale 1ns / 1ps
module cts_back
	import cts_pkg::*;
#(
	parameter int MAX_EQUATIONS = DEF_MAX_EQUATIONS,
	parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             job_valid,
	input  logic [$clog2(MAX_EQUATIONS+1):0] job_data,
	output logic                             job_pop,
	output logic                             active,
	output logic [$clog2(MAX_EQUATIONS)-1:0] mem_addr,
	input  row_t                             mem_rd,
	output logic                             mem_we,
	output row_t                             mem_wr,
	output logic                             result_valid,
	output out_t                             result
);
	localparam int AW = $clog2(MAX_EQUATIONS);
	localparam int CW = $clog2(MAX_EQUATIONS + 1);
	localparam int NS = 30;

	typedef enum logic [NS-1:0] {
		ST_IDLE   = NS'(1) << 0,
		ST_F_RD   = NS'(1) << 1,
		ST_F_LAT  = NS'(1) << 2,
		ST_P_DIV  = NS'(1) << 3,
		ST_P_M1   = NS'(1) << 4,
		ST_P_A1   = NS'(1) << 5,
		ST_P_M2   = NS'(1) << 6,
		ST_P_A2   = NS'(1) << 7,
		ST_P_M3   = NS'(1) << 8,
		ST_P_A3   = NS'(1) << 9,
		ST_FW_DIV = NS'(1) << 10,
		ST_FW_M1  = NS'(1) << 11,
		ST_FW_A1  = NS'(1) << 12,
		ST_FW_M2  = NS'(1) << 13,
		ST_FW_A2  = NS'(1) << 14,
		ST_F_WR   = NS'(1) << 15,
		ST_B_RD   = NS'(1) << 16,
		ST_B_LAT  = NS'(1) << 17,
		ST_BK_DIV = NS'(1) << 18,
		ST_BK_M   = NS'(1) << 19,
		ST_BK_A   = NS'(1) << 20,
		ST_X_DIV  = NS'(1) << 21,
		ST_Y_M1   = NS'(1) << 22,
		ST_Y_A1   = NS'(1) << 23,
		ST_Y_M2   = NS'(1) << 24,
		ST_Y_A2   = NS'(1) << 25,
		ST_Y_DIV  = NS'(1) << 26,
		ST_B_WR   = NS'(1) << 27,
		ST_O_RD   = NS'(1) << 28,
		ST_O_EMIT = NS'(1) << 29
	} state_t;

	state_t state_q;
	logic [AW-1:0] idx_q;
	logic [CW-1:0] n_q;
	logic          fault_q;

	// current row and carried neighbor values
	logic signed [DW-1:0] ra_q, rb_q, rc_q, rd_q, re_q, rf_q, rg_q, rh_q;
	logic                 cpl_q;
	logic signed [DW-1:0] pb_q, pc_q, pd_q;
	logic signed [DW-1:0] nb_q, nd_q, nx_q;
	logic signed [DW-1:0] k_q, rx_q, ry_q, rt_q;
	logic signed [2*DW-1:0] prod_q;

	logic is_last, is_div, div_start, div_busy, div_done, div_flt, other;
	logic signed [DW-1:0] div_num, div_den, div_quo;
	logic signed [DW-1:0] mop_a, mop_b, sub_lhs;
	logic signed [2*DW-1:0] prod_sh;
	sres_t negk, mres, sres;

	assign is_last = (CW'(idx_q) + CW'(1) == n_q);
	assign other = cpl_q && !is_last;
	assign active = (state_q != ST_IDLE);
	assign job_pop = (state_q == ST_IDLE) && job_valid;
	assign mem_addr = idx_q;

	// operand selection for the shared multiplier and divider
	assign negk = sat_neg(k_q);
	assign prod_sh = prod_q >>> FRACTION_BITS;
	assign mres = sat_wide(prod_sh);
	assign sres = sat_sub(sub_lhs, mres.v);

	always_comb begin
		mop_a = k_q;
		mop_b = re_q;
		div_num = rc_q;
		div_den = rf_q;
		sub_lhs = rb_q;
		unique case (state_q)
			ST_P_M2:  begin mop_a = negk.v; mop_b = rg_q; end
			ST_P_M3:  mop_b = rh_q;
			ST_FW_M1: mop_b = pc_q;
			ST_FW_M2: mop_b = pd_q;
			ST_BK_M:  mop_b = nd_q;
			ST_Y_M1:  begin mop_a = re_q; mop_b = rx_q; end
			ST_Y_M2:  begin mop_a = rg_q; mop_b = nx_q; end
			ST_FW_DIV: begin div_num = ra_q; div_den = pb_q; end
			ST_BK_DIV: begin div_num = rc_q; div_den = nb_q; end
			ST_X_DIV:  begin div_num = rd_q; div_den = rb_q; end
			ST_Y_DIV:  begin div_num = rt_q; div_den = rf_q; end
			ST_P_A3, ST_FW_A2, ST_BK_A: sub_lhs = rd_q;
			ST_Y_A1: sub_lhs = rh_q;
			ST_Y_A2: sub_lhs = rt_q;
			default: ;
		endcase
	end

	assign is_div = (state_q == ST_P_DIV) || (state_q == ST_FW_DIV) ||
		(state_q == ST_BK_DIV) || (state_q == ST_X_DIV) || (state_q == ST_Y_DIV);
	assign div_start = is_div && !div_busy && !div_done;

	cts_div #(.FRAC(FRACTION_BITS)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.busy  (div_busy),
		.done  (div_done),
		.quo   (div_quo),
		.fault (div_flt)
	);

	// write-back of a row
	always_comb begin
		mem_we = (state_q == ST_F_WR) || (state_q == ST_B_WR);
		mem_wr = '{a: ra_q, b: rb_q, c: rc_q, d: rd_q, e: re_q, f: rf_q, g: rg_q,
			h: rh_q, cpl: cpl_q};
		if (state_q == ST_B_WR) begin
			mem_wr.d = rx_q;
			mem_wr.h = other ? ry_q : '0;
			mem_wr.cpl = other;
		end
	end

	// result readout
	assign result_valid = (state_q == ST_O_EMIT);
	assign result = '{row_index: ROW_IDX_W'(idx_q), solution: mem_rd.d,
		other_solution: mem_rd.h, has_other: mem_rd.cpl, divide_fault: fault_q,
		last_result: is_last};

	// control sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			n_q <= '0;
			fault_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (job_valid) begin
					n_q <= job_data[CW:1];
					fault_q <= job_data[0];
					idx_q <= '0;
					state_q <= ST_F_RD;
				end
				ST_F_RD: state_q <= ST_F_LAT;
				ST_F_LAT: begin
					if (mem_rd.cpl && !is_last) state_q <= ST_P_DIV;
					else if (idx_q != '0) state_q <= ST_FW_DIV;
					else state_q <= ST_F_WR;
				end
				ST_P_DIV: if (div_done) begin
					fault_q <= fault_q | div_flt;
					state_q <= ST_P_M1;
				end
				ST_P_M1: state_q <= ST_P_A1;
				ST_P_A1: begin
					fault_q <= fault_q | mres.ovf | sres.ovf;
					state_q <= ST_P_M2;
				end
				ST_P_M2: begin
					fault_q <= fault_q | negk.ovf;
					state_q <= ST_P_A2;
				end
				ST_P_A2: begin
					fault_q <= fault_q | mres.ovf;
					state_q <= ST_P_M3;
				end
				ST_P_M3: state_q <= ST_P_A3;
				ST_P_A3: begin
					fault_q <= fault_q | mres.ovf | sres.ovf;
					state_q <= (idx_q != '0) ? ST_FW_DIV : ST_F_WR;
				end
				ST_FW_DIV: if (div_done) begin
					fault_q <= fault_q | div_flt;
					state_q <= ST_FW_M1;
				end
				ST_FW_M1: state_q <= ST_FW_A1;
				ST_FW_A1: begin
					fault_q <= fault_q | mres.ovf | sres.ovf;
					state_q <= ST_FW_M2;
				end
				ST_FW_M2: state_q <= ST_FW_A2;
				ST_FW_A2: begin
					fault_q <= fault_q | mres.ovf | sres.ovf;
					state_q <= ST_F_WR;
				end
				ST_F_WR: begin
					if (is_last) begin
						state_q <= ST_B_RD;
					end else begin
						idx_q <= idx_q + AW'(1);
						state_q <= ST_F_RD;
					end
				end
				ST_B_RD: state_q <= ST_B_LAT;
				ST_B_LAT: state_q <= is_last ? ST_X_DIV : ST_BK_DIV;
				ST_BK_DIV: if (div_done) begin
					fault_q <= fault_q | div_flt;
					state_q <= ST_BK_M;
				end
				ST_BK_M: state_q <= ST_BK_A;
				ST_BK_A: begin
					fault_q <= fault_q | mres.ovf | sres.ovf;
					state_q <= ST_X_DIV;
				end
				ST_X_DIV: if (div_done) begin
					fault_q <= fault_q | div_flt;
					state_q <= other ? ST_Y_M1 : ST_B_WR;
				end
				ST_Y_M1: state_q <= ST_Y_A1;
				ST_Y_A1: begin
					fault_q <= fault_q | mres.ovf | sres.ovf;
					state_q <= ST_Y_M2;
				end
				ST_Y_M2: state_q <= ST_Y_A2;
				ST_Y_A2: begin
					fault_q <= fault_q | mres.ovf | sres.ovf;
					state_q <= ST_Y_DIV;
				end
				ST_Y_DIV: if (div_done) begin
					fault_q <= fault_q | div_flt;
					state_q <= ST_B_WR;
				end
				ST_B_WR: begin
					if (idx_q == '0) begin
						state_q <= ST_O_RD;
					end else begin
						idx_q <= idx_q - AW'(1);
						state_q <= ST_B_RD;
					end
				end
				ST_O_RD: state_q <= ST_O_EMIT;
				ST_O_EMIT: begin
					if (is_last) begin
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + AW'(1);
						state_q <= ST_O_RD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_F_LAT, ST_B_LAT: begin
				ra_q <= mem_rd.a;
				rb_q <= mem_rd.b;
				rc_q <= mem_rd.c;
				rd_q <= mem_rd.d;
				re_q <= mem_rd.e;
				rf_q <= mem_rd.f;
				rg_q <= mem_rd.g;
				rh_q <= mem_rd.h;
				cpl_q <= (state_q == ST_F_LAT) ? (mem_rd.cpl && !is_last) : mem_rd.cpl;
			end
			ST_P_DIV, ST_FW_DIV, ST_BK_DIV: if (div_done) k_q <= div_quo;
			ST_X_DIV: if (div_done) rx_q <= div_quo;
			ST_Y_DIV: if (div_done) ry_q <= div_quo;
			ST_P_M1, ST_P_M2, ST_P_M3, ST_FW_M1, ST_FW_M2, ST_BK_M, ST_Y_M1, ST_Y_M2:
				prod_q <= mop_a * mop_b;
			ST_P_A1, ST_FW_A1: rb_q <= sres.v;
			ST_P_A2: rc_q <= mres.v;
			ST_P_A3, ST_FW_A2, ST_BK_A: rd_q <= sres.v;
			ST_Y_A1, ST_Y_A2: rt_q <= sres.v;
			ST_F_WR: begin
				pb_q <= rb_q;
				pc_q <= rc_q;
				pd_q <= rd_q;
			end
			ST_B_WR: begin
				nb_q <= rb_q;
				nd_q <= rd_q;
				nx_q <= rx_q;
			end
			default: ;
		endcase
	end
endmodule

// ===== bench/coupled_tridiagonal_solver_core_test.sv =====
// Self-checking testbench for the coupled tridiagonal solver core.
`timescale 1ns / 1ps
module coupled_tridiagonal_solver_core_test;
	import cts_pkg::*;

	localparam int NEQ = 64;
	localparam int FB = 16;
	localparam int DEPTH_SIZE = 12;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	in_t item;
	logic result_valid;
	out_t result;

	coupled_tridiagonal_solver_core u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.item(item), .result_valid(result_valid), .result(result)
	);

	// predictor state
	logic signed [31:0] sa[NEQ], sb[NEQ], sc[NEQ], sd[NEQ];
	logic signed [31:0] se[NEQ], sf[NEQ], sg[NEQ], sh[NEQ];
	logic scpl[NEQ];
	int rows_held;
	bit fault_flag;

	out_t solution_queue[$];
	int failures;
	int results_seen;
	int systems_solved;
	int faults_seen;
	int coupled_seen;

	function automatic logic signed [31:0] clamp(input longint x);
		if (x > 64'sd2147483647) begin
			fault_flag = 1;
			return 32'h7fffffff;
		end
		if (x < -64'sd2147483648) begin
			fault_flag = 1;
			return 32'h80000000;
		end
		return x[31:0];
	endfunction

	function automatic logic signed [31:0] q_sub(input logic signed [31:0] p,
			input logic signed [31:0] q);
		return clamp(longint'(p) - longint'(q));
	endfunction

	// product rounded toward minus infinity (arithmetic shift floors)
	function automatic logic signed [31:0] q_mul(input logic signed [31:0] p,
			input logic signed [31:0] q);
		longint x;
		x = longint'(p) * longint'(q);
		return clamp(x >>> FB);
	endfunction

	// quotient truncated toward zero, saturating divide by zero
	function automatic logic signed [31:0] q_div(input logic signed [31:0] num,
			input logic signed [31:0] den);
		if (den == 0) begin
			fault_flag = 1;
			if (num > 0) return 32'h7fffffff;
			if (num < 0) return 32'h80000000;
			return 0;
		end
		return clamp((longint'(num) * 65536) / longint'(den));
	endfunction

	task automatic solve_system(input int n);
		logic signed [31:0] k;
		out_t r;
		bit other;
		for (int i = 0; i + 1 < n; i++) begin
			if (!scpl[i]) continue;
			k = q_div(sc[i], sf[i]);
			sb[i] = q_sub(sb[i], q_mul(k, se[i]));
			sc[i] = q_mul(clamp(-longint'(k)), sg[i]);
			sd[i] = q_sub(sd[i], q_mul(k, sh[i]));
		end
		for (int i = 1; i < n; i++) begin
			k = q_div(sa[i], sb[i-1]);
			sb[i] = q_sub(sb[i], q_mul(k, sc[i-1]));
			sd[i] = q_sub(sd[i], q_mul(k, sd[i-1]));
		end
		for (int i = n - 1; i > 0; i--) begin
			k = q_div(sc[i-1], sb[i]);
			sd[i-1] = q_sub(sd[i-1], q_mul(k, sd[i]));
		end
		for (int i = 0; i < n; i++) sd[i] = q_div(sd[i], sb[i]);
		for (int i = 0; i + 1 < n; i++) begin
			if (!scpl[i]) continue;
			sh[i] = q_div(q_sub(q_sub(sh[i], q_mul(se[i], sd[i])),
				q_mul(sg[i], sd[i+1])), sf[i]);
		end
		for (int i = 0; i < n; i++) begin
			other = scpl[i] && (i + 1 < n);
			r.row_index = i[5:0];
			r.solution = sd[i];
			r.other_solution = other ? sh[i] : 32'sd0;
			r.has_other = other;
			r.divide_fault = fault_flag;
			r.last_result = (i + 1 == n);
			solution_queue.push_back(r);
		end
		if (fault_flag) faults_seen++;
		systems_solved++;
	endtask

	// predict the results an accepted row causes
	task automatic predict_row(input in_t it);
		int i;
		if (rows_held < NEQ) begin
			i = rows_held;
			sa[i] = it.a_coef; sb[i] = it.b_coef; sc[i] = it.c_coef; sd[i] = it.d_coef;
			se[i] = it.e_coef; sf[i] = it.f_coef; sg[i] = it.g_coef; sh[i] = it.h_coef;
			scpl[i] = it.coupled;
			rows_held++;
		end else begin
			fault_flag = 1;
		end
		if (!it.last_row) return;
		scpl[rows_held - 1] = 0;
		solve_system(rows_held);
		rows_held = 0;
		fault_flag = 0;
	endtask

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("coupled_tridiagonal_solver_core_test failed");
		$finish;
	end

	// check each result transfer against the oldest expectation
	always @(posedge clk) begin
		out_t want;
		if (arst_n && result_valid) begin
			results_seen <= results_seen + 1;
			if (solution_queue.size() == 0) begin
				$error("unexpected result row_index=%0d", result.row_index);
				failures <= failures + 1;
			end else begin
				want = solution_queue.pop_front();
				if (result.has_other) coupled_seen <= coupled_seen + 1;
				if (result.row_index !== want.row_index) begin
					$error("row_index exp %0d got %0d", want.row_index, result.row_index);
					failures <= failures + 1;
				end
				if (result.solution !== want.solution) begin
					$error("solution exp %0d got %0d", want.solution, result.solution);
					failures <= failures + 1;
				end
				if (result.other_solution !== want.other_solution) begin
					$error("other_solution exp %0d got %0d", want.other_solution,
						result.other_solution);
					failures <= failures + 1;
				end
				if (result.has_other !== want.has_other) begin
					$error("has_other exp %0d got %0d", want.has_other, result.has_other);
					failures <= failures + 1;
				end
				if (result.divide_fault !== want.divide_fault) begin
					$error("divide_fault exp %0d got %0d", want.divide_fault,
						result.divide_fault);
					failures <= failures + 1;
				end
				if (result.last_result !== want.last_result) begin
					$error("last_result exp %0d got %0d", want.last_result,
						result.last_result);
					failures <= failures + 1;
				end
			end
		end
	end

	// stimulus table row with an optional typed-in expectation for a one-row system
	typedef struct {
		in_t row;
		bit has_want;
		logic signed [31:0] want_x;
		bit want_fault;
	} stim_t;

	stim_t directed[$];
	bit calm;

	function automatic logic signed [31:0] rnd_word();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'h7fffffff;
			2: return 32'h80000000;
			3: return 0;
			default: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
		endcase
	endfunction

	function automatic in_t rnd_row(input bit fin);
		in_t r;
		r.a_coef = rnd_word(); r.b_coef = rnd_word();
		r.c_coef = rnd_word(); r.d_coef = rnd_word();
		r.e_coef = rnd_word(); r.f_coef = rnd_word();
		r.g_coef = rnd_word(); r.h_coef = rnd_word();
		// mostly well-conditioned diagonals so the solve stays out of saturation
		if ($urandom_range(0, 3) != 0) begin
			r.b_coef = 32'sh40000 + $signed($urandom_range(0, 32'h3ffff));
			r.f_coef = 32'sh20000 + $signed($urandom_range(0, 32'h1ffff));
			r.a_coef = $signed($urandom_range(0, 32'h1ffff)) - 32'sh10000;
			r.c_coef = $signed($urandom_range(0, 32'h1ffff)) - 32'sh10000;
		end
		r.coupled = $urandom_range(0, 1);
		r.last_row = fin;
		return r;
	endfunction

	function automatic in_t plain_row(input logic signed [31:0] b,
			input logic signed [31:0] d, input bit cpl, input bit fin);
		in_t r;
		r = '0;
		r.b_coef = b; r.d_coef = d; r.coupled = cpl; r.last_row = fin;
		r.f_coef = 32'sh10000;
		return r;
	endfunction

	function automatic stim_t entry(input in_t r, input bit hw,
			input logic signed [31:0] x, input bit fl);
		stim_t s;
		s.row = r; s.has_want = hw; s.want_x = x; s.want_fault = fl;
		return s;
	endfunction

	// one row transfer, with random sender gaps outside calm stretches;
	// start stays high afterwards until the next row or a drain replaces it
	task automatic send_row(input in_t r);
		if (!calm) begin
			while ($urandom_range(0, 99) < 31) begin
				start <= 0;
				@(posedge clk);
			end
		end
		start <= 1;
		item <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_row(r);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		start <= 0;
		while (solution_queue.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (20) @(posedge clk);
	endtask

	initial begin
		stim_t s;
		int sent;
		int n;
		failures = 0; results_seen = 0; systems_solved = 0;
		faults_seen = 0; coupled_seen = 0;
		rows_held = 0; fault_flag = 0;
		start = 0; item = '0; calm = 0;
		arst_n = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// single-row systems: x = d / b
		directed.push_back(entry(plain_row(32'sh10000, 32'sh30000, 1, 1), 1, 32'sh30000, 0));
		directed.push_back(entry(plain_row(0, 32'sh10000, 0, 1), 1, 32'h7fffffff, 1));
		directed.push_back(entry(plain_row(0, -32'sh10000, 0, 1), 1, 32'h80000000, 1));
		directed.push_back(entry(plain_row(0, 0, 0, 1), 1, 0, 1));
		directed.push_back(entry(plain_row(32'sh10000, 32'h7fffffff, 0, 1), 1, 32'h7fffffff, 0));
		directed.push_back(entry(plain_row(-32'sh10000, 32'h80000000, 0, 1), 1,
			32'h7fffffff, 1));
		directed.push_back(entry(plain_row(32'sh20000, 32'h80000000, 0, 1), 1,
			32'hc0000000, 0));
		// coupled pair, three rows of extreme coefficients, pair with a zero f divisor
		directed.push_back(entry(rnd_row(0), 0, 0, 0));
		directed[$].row.coupled = 1;
		directed.push_back(entry(rnd_row(1), 0, 0, 0));
		directed[$].row.coupled = 1;
		s = entry('1, 0, 0, 0);
		s.row.last_row = 0;
		directed.push_back(s);
		directed.push_back(entry(plain_row(32'h7fffffff, 32'h80000000, 1, 0), 0, 0, 0));
		directed.push_back(entry('1, 0, 0, 0));
		directed.push_back(entry(plain_row(32'sh10000, 32'sh10000, 1, 0), 0, 0, 0));
		directed[$].row.f_coef = 0;
		directed[$].row.c_coef = 32'sh8000;
		directed.push_back(entry(plain_row(32'sh10000, 32'sh10000, 0, 1), 0, 0, 0));

		foreach (directed[i]) begin
			send_row(directed[i].row);
			if (directed[i].has_want) begin
				solution_queue[$].solution = directed[i].want_x;
				solution_queue[$].divide_fault = directed[i].want_fault;
			end
		end
		drain();

		// full store, then overflow rows dropped, closed by a dropped last row
		for (int i = 0; i < NEQ + 2; i++) send_row(rnd_row(i == NEQ + 1));
		drain();

		// random systems, mostly small, one calm stretch and one pause to empty
		sent = 0;
		while (sent < 220) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, NEQ) :
				$urandom_range(1, DEPTH_SIZE);
			if (n > 220 - sent) n = 220 - sent;
			calm = (sent >= 100 && sent < 160);
			for (int i = 0; i < n; i++) send_row(rnd_row(i == n - 1));
			sent += n;
			if (sent > 200 && sent - n <= 200) drain();
		end
		drain();

		$display("covered %0d solved systems, %0d results, %0d with faults, %0d coupled rows",
			systems_solved, results_seen, faults_seen, coupled_seen);
		if (failures == 0 && solution_queue.size() == 0) begin
			$display("coupled_tridiagonal_solver_core_test passed");
		end else begin
			$display("coupled_tridiagonal_solver_core_test failed");
		end
		$finish;
	end
endmodule
